/* sv/psl2_gf343_matrix_unit_assert.svh */
// ----------------------------------------------------------------------------
// psl2 assertion macros
// Implication checks shared by the matrix unit modules.
// ----------------------------------------------------------------------------
`ifndef PSL2_GF343_MATRIX_UNIT_ASSERT_SVH
`define PSL2_GF343_MATRIX_UNIT_ASSERT_SVH

// same-cycle implication
`define PSL2_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psl2 check failed");

// next-cycle implication
`define PSL2_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psl2 check failed");

`endif

/* sv/psl2_pkg.sv */
// ----------------------------------------------------------------------------
// psl2_pkg
// Types, constants and GF(7^3) digit arithmetic for the matrix unit.
// ----------------------------------------------------------------------------
package psl2_pkg;

    localparam int EXP_BITS = 16;
    localparam int EXP_W    = 16;
    localparam int LOOP_N   = (EXP_BITS < EXP_W) ? EXP_BITS : EXP_W;
    localparam int BIT_W    = (LOOP_N > 1) ? $clog2(LOOP_N) : 1;
    localparam logic [EXP_W-1:0] EXP_MASK =
        (EXP_BITS >= EXP_W) ? {EXP_W{1'b1}} : EXP_W'((64'd1 << EXP_BITS) - 64'd1);
    localparam logic [8:0] INV_EXP = 9'd341;

    // three base-7 digits, index 0 is the constant term
    typedef logic [2:0][2:0] gf_t;

    typedef enum logic [1:0] {
        REQ_MUL  = 2'd0,
        REQ_INV  = 2'd1,
        REQ_POW  = 2'd2,
        REQ_TEST = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO     = 2'd1,
        ST_SINGULAR = 2'd2
    } status_t;

    localparam gf_t GF_ZERO = '0;
    localparam gf_t GF_ONE  = {3'd0, 3'd0, 3'd1};
    localparam gf_t [3:0] MAT_IDENT = {GF_ONE, GF_ZERO, GF_ZERO, GF_ONE};

    typedef struct packed {
        req_t             req;
        gf_t [3:0]        left;
        gf_t [3:0]        right;
        logic [EXP_W-1:0] exponent;
    } job_t;

    typedef struct packed {
        gf_t [3:0] m;
        status_t   status;
        logic      ident;
    } result_t;

    function automatic logic [8:0] div7(input logic [8:0] x);
        logic [19:0] p;
        p = 20'(x) * 20'd293;
        return p[19:11];
    endfunction

    function automatic logic [2:0] mod7(input logic [8:0] x);
        logic [8:0]  q;
        logic [11:0] r;
        q = div7(x);
        r = 12'(x) - 12'(q) * 12'd7;
        return r[2:0];
    endfunction

    function automatic gf_t gf_norm(input logic [8:0] v);
        logic [8:0] q7;
        logic [8:0] q49;
        gf_t        n;
        q7   = div7(v);
        q49  = div7(q7);
        n[0] = mod7(v);
        n[1] = mod7(q7);
        n[2] = mod7(q49);
        return n;
    endfunction

    function automatic logic [8:0] gf_enc(input gf_t a);
        return 9'(a[0]) + 9'(a[1]) * 9'd7 + 9'(a[2]) * 9'd49;
    endfunction

    function automatic logic [2:0] dig_add(input logic [2:0] x, input logic [2:0] y);
        logic [3:0] s;
        s = {1'b0, x} + {1'b0, y};
        return (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
    endfunction

    function automatic gf_t gf_add(input gf_t a, input gf_t b);
        gf_t s;
        for (int i = 0; i < 3; i++)
        begin
            s[i] = dig_add(a[i], b[i]);
        end
        return s;
    endfunction

    function automatic gf_t gf_neg(input gf_t a);
        gf_t n;
        for (int i = 0; i < 3; i++)
        begin
            n[i] = (a[i] == 3'd0) ? 3'd0 : 3'(4'd7 - {1'b0, a[i]});
        end
        return n;
    endfunction

    function automatic logic [8:0] pm(input logic [2:0] x, input logic [2:0] y);
        return 9'(x) * 9'(y);
    endfunction

    function automatic gf_t gf_mul(input gf_t a, input gf_t b);
        logic [8:0] c0;
        logic [8:0] c1;
        logic [8:0] c2;
        c0 = pm(a[0], b[0]) + ((pm(a[1], b[2]) + pm(a[2], b[1])) << 1);
        c1 = pm(a[0], b[1]) + pm(a[1], b[0]) + (pm(a[2], b[2]) << 1);
        c2 = pm(a[0], b[2]) + pm(a[1], b[1]) + pm(a[2], b[0]);
        return {mod7(c2), mod7(c1), mod7(c0)};
    endfunction

endpackage

/* sv/psl2_gfmul.sv */
// ----------------------------------------------------------------------------
// psl2_gfmul
// Shared GF(7^3) multiply-accumulate unit with a registered product.
// ----------------------------------------------------------------------------
module psl2_gfmul
    import psl2_pkg::*;
(
    input  logic clk,
    input  logic en,
    input  logic acc_en,
    input  gf_t  op_a,
    input  gf_t  op_b,
    output gf_t  prod
);

    gf_t prod_reg;
    gf_t prod_next;
    gf_t mul_val;

    assign mul_val   = gf_mul(op_a, op_b);
    assign prod_next = acc_en ? gf_add(mul_val, prod_reg) : mul_val;
    assign prod      = prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

/* sv/psl2_core.sv */
// ----------------------------------------------------------------------------
// psl2_core
// Sequencer for matrix products, adjugate, power and canonical scaling.
// ----------------------------------------------------------------------------
`include "psl2_gf343_matrix_unit_assert.svh"

module psl2_core
    import psl2_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  job_t    job,
    output logic    idle,
    output logic    done,
    input  logic    ack,
    output result_t result
);

    typedef enum logic [3:0] {
        S_IDLE, S_DET, S_DETCHK, S_MM, S_MMW, S_PBIT, S_PSQ, S_CANON,
        S_INVLD, S_INVSQ, S_INVMU, S_INVST, S_SCALE, S_DONE
    } state_t;

    state_t           state_reg;
    req_t             req_reg;
    logic [EXP_W-1:0] exp_reg;
    status_t          status_reg;
    logic [3:0]       cnt_reg;
    logic [BIT_W-1:0] bit_reg;
    logic             sq_reg;
    gf_t [3:0]        r_reg;
    gf_t [3:0]        m_reg;
    gf_t [2:0]        t_reg;
    gf_t              piv_reg;
    gf_t              inv_reg;

    logic mul_en;
    logic acc_en;
    gf_t  op_a;
    gf_t  op_b;
    gf_t  prod;
    gf_t  piv;
    logic piv_found;

    psl2_gfmul u_mul (
        .clk    (clk),
        .en     (mul_en),
        .acc_en (acc_en),
        .op_a   (op_a),
        .op_b   (op_b),
        .prod   (prod)
    );

    always_comb
    begin
        op_a   = GF_ZERO;
        op_b   = GF_ZERO;
        acc_en = 1'b0;
        mul_en = 1'b0;
        unique case (state_reg)
            S_DET:
            begin
                mul_en = 1'b1;
                if (!cnt_reg[0])
                begin
                    op_a = r_reg[0];
                    op_b = r_reg[3];
                end
                else
                begin
                    op_a   = r_reg[1];
                    op_b   = gf_neg(r_reg[2]);
                    acc_en = 1'b1;
                end
            end
            S_MM:
            begin
                mul_en = 1'b1;
                op_a   = sq_reg ? m_reg[{cnt_reg[2], cnt_reg[0]}]
                                : r_reg[{cnt_reg[2], cnt_reg[0]}];
                op_b   = m_reg[{cnt_reg[0], cnt_reg[1]}];
                acc_en = cnt_reg[0];
            end
            S_INVLD:
            begin
                mul_en = 1'b1;
                op_a   = piv_reg;
                op_b   = GF_ONE;
            end
            S_INVSQ:
            begin
                mul_en = 1'b1;
                op_a   = prod;
                op_b   = prod;
            end
            S_INVMU:
            begin
                mul_en = 1'b1;
                op_a   = prod;
                op_b   = piv_reg;
            end
            S_SCALE:
            begin
                mul_en = 1'b1;
                op_a   = inv_reg;
                op_b   = r_reg[cnt_reg[1:0]];
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        piv_found = 1'b1;
        priority if (r_reg[0] != GF_ZERO) piv = r_reg[0];
        else if (r_reg[1] != GF_ZERO)     piv = r_reg[1];
        else if (r_reg[2] != GF_ZERO)     piv = r_reg[2];
        else if (r_reg[3] != GF_ZERO)     piv = r_reg[3];
        else
        begin
            piv       = GF_ZERO;
            piv_found = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            bit_reg   <= '0;
            sq_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg    <= job.req;
                        exp_reg    <= job.exponent & EXP_MASK;
                        status_reg <= ST_OK;
                        cnt_reg    <= '0;
                        bit_reg    <= '0;
                        sq_reg     <= 1'b0;
                        unique case (job.req)
                            REQ_MUL:
                            begin
                                r_reg     <= job.left;
                                m_reg     <= job.right;
                                state_reg <= S_MM;
                            end
                            REQ_INV:
                            begin
                                r_reg     <= job.left;
                                state_reg <= S_DET;
                            end
                            REQ_POW, REQ_TEST:
                            begin
                                r_reg     <= MAT_IDENT;
                                m_reg     <= job.left;
                                state_reg <= S_PBIT;
                            end
                        endcase
                    end
                end
                S_DET:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg[0])
                    begin
                        state_reg <= S_DETCHK;
                    end
                end
                S_DETCHK:
                begin
                    if (prod == GF_ZERO)
                    begin
                        status_reg <= ST_SINGULAR;
                        r_reg      <= '0;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        r_reg[0]  <= r_reg[3];
                        r_reg[1]  <= gf_neg(r_reg[1]);
                        r_reg[2]  <= gf_neg(r_reg[2]);
                        r_reg[3]  <= r_reg[0];
                        state_reg <= S_CANON;
                    end
                end
                S_MM:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg != 4'd0 && !cnt_reg[0])
                    begin
                        t_reg[cnt_reg[2:1] - 2'd1] <= prod;
                    end
                    if (cnt_reg == 4'd7)
                    begin
                        state_reg <= S_MMW;
                    end
                end
                S_MMW:
                begin
                    if (sq_reg)
                    begin
                        m_reg     <= {prod, t_reg[2], t_reg[1], t_reg[0]};
                        state_reg <= S_PBIT;
                    end
                    else
                    begin
                        r_reg     <= {prod, t_reg[2], t_reg[1], t_reg[0]};
                        state_reg <= (req_reg == REQ_MUL) ? S_CANON : S_PSQ;
                    end
                end
                S_PBIT:
                begin
                    cnt_reg <= '0;
                    sq_reg  <= 1'b0;
                    if (exp_reg[bit_reg])
                    begin
                        state_reg <= S_MM;
                    end
                    else
                    begin
                        state_reg <= S_PSQ;
                    end
                end
                S_PSQ:
                begin
                    if (bit_reg == BIT_W'(LOOP_N - 1))
                    begin
                        state_reg <= S_CANON;
                    end
                    else
                    begin
                        bit_reg   <= bit_reg + 1'b1;
                        sq_reg    <= 1'b1;
                        cnt_reg   <= '0;
                        state_reg <= S_MM;
                    end
                end
                S_CANON:
                begin
                    if (!piv_found)
                    begin
                        status_reg <= ST_ZERO;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        piv_reg   <= piv;
                        state_reg <= S_INVLD;
                    end
                end
                S_INVLD:
                begin
                    cnt_reg   <= 4'd7;
                    state_reg <= S_INVSQ;
                end
                S_INVSQ:
                begin
                    if (INV_EXP[cnt_reg[2:0]])
                    begin
                        state_reg <= S_INVMU;
                    end
                    else if (cnt_reg == 4'd0)
                    begin
                        state_reg <= S_INVST;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 4'd1;
                    end
                end
                S_INVMU:
                begin
                    if (cnt_reg == 4'd0)
                    begin
                        state_reg <= S_INVST;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg - 4'd1;
                        state_reg <= S_INVSQ;
                    end
                end
                S_INVST:
                begin
                    inv_reg   <= prod;
                    cnt_reg   <= '0;
                    state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg != 4'd0)
                    begin
                        r_reg[cnt_reg[1:0] - 2'd1] <= prod;
                    end
                    if (cnt_reg == 4'd4)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (ack)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign idle          = (state_reg == S_IDLE);
    assign done          = (state_reg == S_DONE);
    assign result.m      = r_reg;
    assign result.status = status_reg;
    assign result.ident  = (req_reg == REQ_TEST) &&
                           ((exp_reg == '0) || (status_reg == ST_OK && r_reg == MAT_IDENT));

    `PSL2_IMPLY(a_singular_inv, done && result.status == ST_SINGULAR, req_reg == REQ_INV)
    `PSL2_IMPLY(a_ident_test, done && result.ident, req_reg == REQ_TEST)
    `PSL2_NEXT(a_start_busy, start && idle, !idle)

endmodule

/* sv/psl2_gf343_matrix_unit.sv */
// ----------------------------------------------------------------------------
// psl2_gf343_matrix_unit
// Projective 2x2 matrix unit over GF(7^3), top level.
// ----------------------------------------------------------------------------
// A request word (req_valid/req_ready) carries the type, the left and right
// matrices and the exponent. One result word (res_valid/res_ready) follows
// each request with the canonical matrix, status and identity flag.
// Requests are served one at a time on a single shared field multiplier;
// req_ready is high only while the sequencer is idle.
// Steps from accept to res_valid:
//   multiply: 8 products, inversion by a^341, 4 scalings
//   inverse:  determinant, adjugate, scaling
//   power/test: square-and-multiply over the exponent bits, then scaling;
//   the multiplier runs one field product per cycle while it is enabled.
// The result sits in an output register; a new request is accepted while it
// waits. If the receiver stalls, the next finished result waits in the
// sequencer until the register frees up.
// Reset clears the sequencer to idle and empties the output register.
// ----------------------------------------------------------------------------
`include "psl2_gf343_matrix_unit_assert.svh"

module psl2_gf343_matrix_unit
    import psl2_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  logic [1:0]       req_type,
    input  logic [8:0]       left_a,
    input  logic [8:0]       left_b,
    input  logic [8:0]       left_c,
    input  logic [8:0]       left_d,
    input  logic [8:0]       right_a,
    input  logic [8:0]       right_b,
    input  logic [8:0]       right_c,
    input  logic [8:0]       right_d,
    input  logic [EXP_W-1:0] exponent,
    output logic             res_valid,
    input  logic             res_ready,
    output logic [8:0]       res_a,
    output logic [8:0]       res_b,
    output logic [8:0]       res_c,
    output logic [8:0]       res_d,
    output logic [1:0]       status,
    output logic             is_identity
);

    job_t    job;
    result_t result;
    logic    start;
    logic    core_idle;
    logic    core_done;
    logic    out_load;
    logic    res_zero;

    logic       res_valid_reg;
    logic [8:0] res_a_reg;
    logic [8:0] res_b_reg;
    logic [8:0] res_c_reg;
    logic [8:0] res_d_reg;
    logic [1:0] status_reg;
    logic       ident_reg;

    assign job.req      = req_t'(req_type);
    assign job.left     = {gf_norm(left_d), gf_norm(left_c), gf_norm(left_b), gf_norm(left_a)};
    assign job.right    = {gf_norm(right_d), gf_norm(right_c),
                           gf_norm(right_b), gf_norm(right_a)};
    assign job.exponent = exponent;

    assign req_ready = core_idle;
    assign start     = req_valid && req_ready;
    assign out_load  = core_done && (!res_valid_reg || res_ready);

    psl2_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .job    (job),
        .idle   (core_idle),
        .done   (core_done),
        .ack    (out_load),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_a_reg  <= gf_enc(result.m[0]);
            res_b_reg  <= gf_enc(result.m[1]);
            res_c_reg  <= gf_enc(result.m[2]);
            res_d_reg  <= gf_enc(result.m[3]);
            status_reg <= 2'(result.status);
            ident_reg  <= result.ident;
        end
    end

    assign res_valid   = res_valid_reg;
    assign res_a       = res_a_reg;
    assign res_b       = res_b_reg;
    assign res_c       = res_c_reg;
    assign res_d       = res_d_reg;
    assign status      = status_reg;
    assign is_identity = ident_reg;

    assign res_zero = ((res_a | res_b | res_c | res_d) == 9'd0) && !is_identity;

    `PSL2_NEXT(a_accept_busy, req_valid && req_ready, !req_ready)
    `PSL2_IMPLY(a_zero_clear, res_valid && status == 2'(ST_ZERO), res_zero)
    `PSL2_IMPLY(a_sing_clear, res_valid && status == 2'(ST_SINGULAR), res_zero)

endmodule

/* sim/psl2_gf343_matrix_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psl2_gf343_matrix_unit_tb
// Checks the projective GF(7^3) matrix unit against a behavioral predictor:
// directed corner requests, then random multiply, inverse, power and identity
// test words under several phases of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module psl2_gf343_matrix_unit_tb
    import psl2_pkg::*;
;

    typedef struct {
        logic [8:0] m [4];
        logic [1:0] st;
        logic       ident;
    } mat_result_t;

    typedef int unsigned mat_t [4];

    function automatic int unsigned fe_norm(int unsigned v);
        return (v % 7) + 7 * ((v / 7) % 7) + 49 * ((v / 49) % 7);
    endfunction

    function automatic int unsigned fe_add(int unsigned a, int unsigned b);
        return ((a % 7 + b % 7) % 7) + 7 * (((a / 7) % 7 + (b / 7) % 7) % 7)
            + 49 * (((a / 49) % 7 + (b / 49) % 7) % 7);
    endfunction

    function automatic int unsigned fe_neg(int unsigned a);
        return ((7 - a % 7) % 7) + 7 * ((7 - (a / 7) % 7) % 7)
            + 49 * ((7 - (a / 49) % 7) % 7);
    endfunction

    function automatic int unsigned fe_mul(int unsigned a, int unsigned b);
        int unsigned a0, a1, a2, b0, b1, b2;
        a0 = a % 7; a1 = (a / 7) % 7; a2 = (a / 49) % 7;
        b0 = b % 7; b1 = (b / 7) % 7; b2 = (b / 49) % 7;
        return ((a0 * b0 + 2 * (a1 * b2 + a2 * b1)) % 7)
            + 7 * ((a0 * b1 + a1 * b0 + 2 * a2 * b2) % 7)
            + 49 * ((a0 * b2 + a1 * b1 + a2 * b0) % 7);
    endfunction

    function automatic int unsigned fe_inv(int unsigned a);
        int unsigned r, e;
        r = 1; e = 341;
        while (e != 0)
        begin
            if (e[0]) r = fe_mul(r, a);
            a = fe_mul(a, a);
            e = e >> 1;
        end
        return r;
    endfunction

    function automatic mat_t scale_canonical(mat_t m);
        int unsigned piv;
        piv = 0;
        for (int i = 0; i < 4 && piv == 0; i++) piv = m[i];
        if (piv != 0)
        begin
            piv = fe_inv(piv);
            for (int i = 0; i < 4; i++) m[i] = fe_mul(piv, m[i]);
        end
        return m;
    endfunction

    function automatic mat_t mat_product(mat_t l, mat_t r);
        mat_t p;
        p[0] = fe_add(fe_mul(l[0], r[0]), fe_mul(l[1], r[2]));
        p[1] = fe_add(fe_mul(l[0], r[1]), fe_mul(l[1], r[3]));
        p[2] = fe_add(fe_mul(l[2], r[0]), fe_mul(l[3], r[2]));
        p[3] = fe_add(fe_mul(l[2], r[1]), fe_mul(l[3], r[3]));
        return scale_canonical(p);
    endfunction

    function automatic mat_result_t predict_matrix(req_t rq, mat_t l, mat_t r,
                                                   logic [15:0] e);
        mat_result_t o;
        mat_t res, sq;
        int unsigned det;
        for (int i = 0; i < 4; i++)
        begin
            l[i] = fe_norm(l[i]);
            r[i] = fe_norm(r[i]);
        end
        o.st = ST_OK;
        o.ident = 1'b0;
        if (rq == REQ_MUL)
        begin
            res = mat_product(l, r);
            if ((res[0] | res[1] | res[2] | res[3]) == 0) o.st = ST_ZERO;
        end
        else if (rq == REQ_INV)
        begin
            det = fe_add(fe_mul(l[0], l[3]), fe_neg(fe_mul(l[1], l[2])));
            if (det == 0)
            begin
                res = '{0, 0, 0, 0};
                o.st = ST_SINGULAR;
            end
            else
                res = scale_canonical('{l[3], fe_neg(l[1]), fe_neg(l[2]), l[0]});
        end
        else
        begin
            res = '{1, 0, 0, 1};
            sq = l;
            for (int i = 0; i < EXP_BITS; i++)
            begin
                if (e[i]) res = mat_product(res, sq);
                sq = mat_product(sq, sq);
            end
            if ((res[0] | res[1] | res[2] | res[3]) == 0) o.st = ST_ZERO;
            if (rq == REQ_TEST)
                o.ident = (e == 0) || (o.st == ST_OK && res[0] == 1 && res[1] == 0
                    && res[2] == 0 && res[3] == 1);
        end
        for (int i = 0; i < 4; i++) o.m[i] = res[i][8:0];
        return o;
    endfunction

    class matrix_scoreboard;
        mat_result_t pending [$];
        int errors = 0;

        function void note_request(req_t rq, mat_t l, mat_t r, logic [15:0] e);
            pending.push_back(predict_matrix(rq, l, r, e));
        endfunction

        function void check_result(logic [8:0] ra, logic [8:0] rb, logic [8:0] rc,
                                   logic [8:0] rd, logic [1:0] st, logic id);
            mat_result_t x;
            if (pending.size() == 0)
            begin
                $error("unexpected result word");
                errors++;
                return;
            end
            x = pending.pop_front();
            if (ra !== x.m[0]) begin $error("res_a exp %0d got %0d", x.m[0], ra); errors++; end
            if (rb !== x.m[1]) begin $error("res_b exp %0d got %0d", x.m[1], rb); errors++; end
            if (rc !== x.m[2]) begin $error("res_c exp %0d got %0d", x.m[2], rc); errors++; end
            if (rd !== x.m[3]) begin $error("res_d exp %0d got %0d", x.m[3], rd); errors++; end
            if (st !== x.st) begin $error("status exp %0d got %0d", x.st, st); errors++; end
            if (id !== x.ident)
            begin
                $error("is_identity exp %0d got %0d", x.ident, id);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    logic [1:0] req_type = '0;
    logic [8:0] left_a = '0, left_b = '0, left_c = '0, left_d = '0;
    logic [8:0] right_a = '0, right_b = '0, right_c = '0, right_d = '0;
    logic [15:0] exponent = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    logic [8:0] res_a, res_b, res_c, res_d;
    logic [1:0] status;
    logic is_identity;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    matrix_scoreboard board = new();

    psl2_gf343_matrix_unit dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            board.check_result(res_a, res_b, res_c, res_d, status, is_identity);
        res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_word(req_t rq, mat_t l, mat_t r, logic [15:0] e);
        while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        req_valid <= 1'b1;
        req_type <= rq;
        {left_a, left_b, left_c, left_d} <= {9'(l[0]), 9'(l[1]), 9'(l[2]), 9'(l[3])};
        {right_a, right_b, right_c, right_d} <= {9'(r[0]), 9'(r[1]), 9'(r[2]), 9'(r[3])};
        exponent <= e;
        do @(posedge clk); while (!req_ready);
        board.note_request(rq, l, r, e);
        req_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int unsigned rand_code();
        int k;
        k = $urandom_range(9);
        if (k == 0) return $urandom_range(511);
        if (k < 3) return $urandom_range(1) * $urandom_range(6);
        return $urandom_range(342);
    endfunction

    function automatic logic [15:0] rand_exp();
        case ($urandom_range(3))
            0: return 16'($urandom_range(15));
            1: return 16'($urandom_range(65535));
            2: return 16'(1 << $urandom_range(15));
            default: return 16'(~(16'(1) << $urandom_range(15)));
        endcase
    endfunction

    task automatic send_random();
        mat_t l, r;
        req_t rq;
        for (int i = 0; i < 4; i++)
        begin
            l[i] = rand_code();
            r[i] = rand_code();
        end
        rq = req_t'($urandom_range(3));
        if ($urandom_range(7) == 0)
        begin
            l[1] = 0;
            l[2] = 0;
        end
        send_word(rq, l, r, rand_exp());
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        mat_t z, id, mx, bad;
        z = '{0, 0, 0, 0};
        id = '{1, 0, 0, 1};
        mx = '{342, 342, 342, 342};
        bad = '{511, 343, 400, 448};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_word(REQ_MUL, z, mx, 0);
        send_word(REQ_MUL, id, mx, 0);
        send_word(REQ_MUL, mx, bad, 16'hFFFF);
        send_word(REQ_MUL, '{0, 1, 0, 0}, '{0, 1, 0, 0}, 0);
        send_word(REQ_INV, z, z, 0);
        send_word(REQ_INV, '{1, 2, 2, 4}, z, 0);
        send_word(REQ_INV, '{0, 5, 100, 0}, z, 0);
        send_word(REQ_INV, bad, mx, 0);
        send_word(REQ_POW, mx, z, 0);
        send_word(REQ_POW, z, z, 0);
        send_word(REQ_POW, '{0, 1, 0, 0}, z, 2);
        send_word(REQ_POW, '{0, 1, 0, 0}, z, 1);
        send_word(REQ_POW, '{0, 1, 0, 0}, z, 16'h8002);
        send_word(REQ_POW, '{3, 1, 1, 9}, z, 16'hFFFF);
        send_word(REQ_TEST, z, z, 0);
        send_word(REQ_TEST, z, z, 5);
        send_word(REQ_TEST, id, z, 16'hFFFF);
        send_word(REQ_TEST, '{0, 1, 1, 0}, z, 2);
        send_word(REQ_TEST, bad, mx, 16'h5555);
        send_word(REQ_TEST, '{0, 6, 1, 0}, z, 16'hAAAA);
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1) ? 47 : (ph == 3) ? 24 : 0;
            recv_stall_pct = (ph == 2) ? 47 : (ph == 3) ? 24 : 0;
            for (int n = 0; n < 270; n++) send_random();
            drain();
        end
        drain();
        repeat (400) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
